>>> hw/rtl/smi_pkg.sv
// ----------------------------------------------------------------------------
// smi_pkg: shared types and operation schedule
// Types, constants and the fixed operation list of the SPD 4x4 inverse core.
// ----------------------------------------------------------------------------
package smi_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int Q_W           = 32;
    localparam int ACC_W         = 36;
    localparam int NSLOT         = 40;
    localparam int SLOT_W        = 6;
    localparam int NOPS          = 90;

    localparam logic signed [ACC_W-1:0] ACC_QMAX = ACC_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] ACC_QMIN = ACC_W'(-64'sh0000_0000_8000_0000);

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PIVOT = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    typedef enum logic [2:0] {
        OP_LOAD = 3'd0,
        OP_CLR  = 3'd1,
        OP_ONE  = 3'd2,
        OP_MAC  = 3'd3,
        OP_SQRT = 3'd4,
        OP_DIV  = 3'd5
    } smi_kind_t;

    // For OP_MAC a and b are the factors, for OP_DIV a is the target and b
    // the divisor, for OP_SQRT a is the target, for OP_LOAD a is the source.
    typedef struct packed {
        smi_kind_t         kind;
        logic              neg;
        logic [SLOT_W-1:0] a;
        logic [SLOT_W-1:0] b;
    } smi_op_t;

    typedef struct packed {
        logic                         valid;
        logic                         bad;
        logic                         sat;
        logic signed [ACC_W-1:0]      acc;
        logic [NSLOT-1:0][Q_W-1:0]    v;
    } smi_ctx_t;

    typedef struct packed {
        logic [63:0]    rem;
        logic [Q_W-1:0] dvs;
        logic [Q_W-1:0] quo;
        logic           neg;
        logic           ovf;
    } smi_div_t;

    typedef struct packed {
        logic [63:0] rad;
        logic [63:0] root;
    } smi_sqrt_t;

    // Working slots: input, factor, inverse factor, result.
    localparam logic [SLOT_W-1:0] S_M00 = 6'd0,  S_M10 = 6'd1,  S_M11 = 6'd2,  S_M20 = 6'd3;
    localparam logic [SLOT_W-1:0] S_M21 = 6'd4,  S_M22 = 6'd5,  S_M30 = 6'd6,  S_M31 = 6'd7;
    localparam logic [SLOT_W-1:0] S_M32 = 6'd8,  S_M33 = 6'd9;
    localparam logic [SLOT_W-1:0] S_L00 = 6'd10, S_L10 = 6'd11, S_L11 = 6'd12, S_L20 = 6'd13;
    localparam logic [SLOT_W-1:0] S_L21 = 6'd14, S_L22 = 6'd15, S_L30 = 6'd16, S_L31 = 6'd17;
    localparam logic [SLOT_W-1:0] S_L32 = 6'd18, S_L33 = 6'd19;
    localparam logic [SLOT_W-1:0] S_U00 = 6'd20, S_U10 = 6'd21, S_U11 = 6'd22, S_U20 = 6'd23;
    localparam logic [SLOT_W-1:0] S_U21 = 6'd24, S_U22 = 6'd25, S_U30 = 6'd26, S_U31 = 6'd27;
    localparam logic [SLOT_W-1:0] S_U32 = 6'd28, S_U33 = 6'd29;
    localparam logic [SLOT_W-1:0] S_R00 = 6'd30, S_R10 = 6'd31, S_R11 = 6'd32, S_R20 = 6'd33;
    localparam logic [SLOT_W-1:0] S_R21 = 6'd34, S_R22 = 6'd35, S_R30 = 6'd36, S_R31 = 6'd37;
    localparam logic [SLOT_W-1:0] S_R32 = 6'd38, S_R33 = 6'd39;
    localparam logic [SLOT_W-1:0] S_NA  = 6'd0;

    localparam smi_op_t OPS [NOPS] = '{
        // Cholesky factor, row by row
        '{OP_LOAD, 1'b0, S_M00, S_NA},  '{OP_SQRT, 1'b0, S_L00, S_NA},
        '{OP_LOAD, 1'b0, S_M10, S_NA},  '{OP_DIV,  1'b0, S_L10, S_L00},
        '{OP_LOAD, 1'b0, S_M20, S_NA},  '{OP_DIV,  1'b0, S_L20, S_L00},
        '{OP_LOAD, 1'b0, S_M30, S_NA},  '{OP_DIV,  1'b0, S_L30, S_L00},
        '{OP_LOAD, 1'b0, S_M11, S_NA},  '{OP_MAC,  1'b1, S_L10, S_L10},
        '{OP_SQRT, 1'b0, S_L11, S_NA},
        '{OP_LOAD, 1'b0, S_M21, S_NA},  '{OP_MAC,  1'b1, S_L20, S_L10},
        '{OP_DIV,  1'b0, S_L21, S_L11},
        '{OP_LOAD, 1'b0, S_M22, S_NA},  '{OP_MAC,  1'b1, S_L20, S_L20},
        '{OP_MAC,  1'b1, S_L21, S_L21}, '{OP_SQRT, 1'b0, S_L22, S_NA},
        '{OP_LOAD, 1'b0, S_M31, S_NA},  '{OP_MAC,  1'b1, S_L30, S_L10},
        '{OP_DIV,  1'b0, S_L31, S_L11},
        '{OP_LOAD, 1'b0, S_M32, S_NA},  '{OP_MAC,  1'b1, S_L30, S_L20},
        '{OP_MAC,  1'b1, S_L31, S_L21}, '{OP_DIV,  1'b0, S_L32, S_L22},
        '{OP_LOAD, 1'b0, S_M33, S_NA},  '{OP_MAC,  1'b1, S_L30, S_L30},
        '{OP_MAC,  1'b1, S_L31, S_L31}, '{OP_MAC,  1'b1, S_L32, S_L32},
        '{OP_SQRT, 1'b0, S_L33, S_NA},
        // Inverse of the factor by forward substitution
        '{OP_ONE,  1'b0, S_NA,  S_NA},  '{OP_DIV,  1'b0, S_U00, S_L00},
        '{OP_ONE,  1'b0, S_NA,  S_NA},  '{OP_DIV,  1'b0, S_U11, S_L11},
        '{OP_ONE,  1'b0, S_NA,  S_NA},  '{OP_DIV,  1'b0, S_U22, S_L22},
        '{OP_ONE,  1'b0, S_NA,  S_NA},  '{OP_DIV,  1'b0, S_U33, S_L33},
        '{OP_CLR,  1'b0, S_NA,  S_NA},  '{OP_MAC,  1'b0, S_U00, S_L10},
        '{OP_DIV,  1'b1, S_U10, S_L11},
        '{OP_CLR,  1'b0, S_NA,  S_NA},  '{OP_MAC,  1'b0, S_U11, S_L21},
        '{OP_DIV,  1'b1, S_U21, S_L22},
        '{OP_CLR,  1'b0, S_NA,  S_NA},  '{OP_MAC,  1'b0, S_U22, S_L32},
        '{OP_DIV,  1'b1, S_U32, S_L33},
        '{OP_CLR,  1'b0, S_NA,  S_NA},  '{OP_MAC,  1'b0, S_U00, S_L20},
        '{OP_MAC,  1'b0, S_U10, S_L21}, '{OP_DIV,  1'b1, S_U20, S_L22},
        '{OP_CLR,  1'b0, S_NA,  S_NA},  '{OP_MAC,  1'b0, S_U11, S_L31},
        '{OP_MAC,  1'b0, S_U21, S_L32}, '{OP_DIV,  1'b1, S_U31, S_L33},
        '{OP_CLR,  1'b0, S_NA,  S_NA},  '{OP_MAC,  1'b0, S_U00, S_L30},
        '{OP_MAC,  1'b0, S_U10, S_L31}, '{OP_MAC,  1'b0, S_U20, S_L32},
        '{OP_DIV,  1'b1, S_U30, S_L33},
        // Back substitution with the transposed factor
        '{OP_LOAD, 1'b0, S_U30, S_NA},  '{OP_DIV,  1'b0, S_R30, S_L33},
        '{OP_LOAD, 1'b0, S_U31, S_NA},  '{OP_DIV,  1'b0, S_R31, S_L33},
        '{OP_LOAD, 1'b0, S_U32, S_NA},  '{OP_DIV,  1'b0, S_R32, S_L33},
        '{OP_LOAD, 1'b0, S_U33, S_NA},  '{OP_DIV,  1'b0, S_R33, S_L33},
        '{OP_LOAD, 1'b0, S_U20, S_NA},  '{OP_MAC,  1'b1, S_L32, S_R30},
        '{OP_DIV,  1'b0, S_R20, S_L22},
        '{OP_LOAD, 1'b0, S_U21, S_NA},  '{OP_MAC,  1'b1, S_L32, S_R31},
        '{OP_DIV,  1'b0, S_R21, S_L22},
        '{OP_LOAD, 1'b0, S_U22, S_NA},  '{OP_MAC,  1'b1, S_L32, S_R32},
        '{OP_DIV,  1'b0, S_R22, S_L22},
        '{OP_LOAD, 1'b0, S_U10, S_NA},  '{OP_MAC,  1'b1, S_L21, S_R20},
        '{OP_MAC,  1'b1, S_L31, S_R30}, '{OP_DIV,  1'b0, S_R10, S_L11},
        '{OP_LOAD, 1'b0, S_U11, S_NA},  '{OP_MAC,  1'b1, S_L21, S_R21},
        '{OP_MAC,  1'b1, S_L31, S_R31}, '{OP_DIV,  1'b0, S_R11, S_L11},
        '{OP_LOAD, 1'b0, S_U00, S_NA},  '{OP_MAC,  1'b1, S_L10, S_R10},
        '{OP_MAC,  1'b1, S_L20, S_R20}, '{OP_MAC,  1'b1, S_L30, S_R30},
        '{OP_DIV,  1'b0, S_R00, S_L00}
    };

endpackage

>>> hw/rtl/spd_matrix_inverse_4x4_core.sv
// ----------------------------------------------------------------------------
// spd_matrix_inverse_4x4_core: inverse of a symmetric positive-definite 4x4
// Cholesky factor, triangular inverse and back substitution in one long chain.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one matrix per transaction: the ten lower-triangle
// elements in signed fixed point, m00 in the lowest 32 bits of s_tdata. The
// master channel returns the ten lower-triangle elements of the inverse in
// the same layout, with the status code in m_tuser (ok, non-positive pivot,
// or saturated). A matrix with a non-positive pivot returns all zeros.
// The datapath is a chain of 90 operation units, each a run of cells that
// hand a full working context to the next every cycle the chain advances:
// accumulator steps that end in a register, multiply-accumulate steps that
// register the product and then the sum, square roots of 32 cells, dividers
// of 34 stages (an entry register, 32 cells with one quotient bit each, and
// an exit register). Throughput is one matrix per cycle when not stalled.
// Reset clears every valid flag; the chain comes up empty.
// When the receiver stalls with a result waiting, the whole chain holds and
// s_tready drops in the same cycle; it rises again once the result is taken.
// ----------------------------------------------------------------------------
module spd_matrix_inverse_4x4_core #(
    parameter int FRAC_BITS = smi_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [319:0] s_tdata,   // m00 m10 m11 m20 m21 m22 m30 m31 m32 m33
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [319:0] m_tdata,   // inv00 inv10 inv11 inv20 inv21 inv22
                                    // inv30 inv31 inv32 inv33
    output logic [1:0]   m_tuser    // status
);
    import smi_pkg::*;

    localparam int NIN = 10;

    smi_ctx_t c [NOPS+1];
    logic     en;

    // The chain advances as a whole whenever the output slot is free or
    // being emptied in this cycle.
    assign en       = !c[NOPS].valid || m_tready;
    assign s_tready = en;

    always_comb
    begin
        c[0]       = '0;
        c[0].valid = s_tvalid;
        for (int k = 0; k < NIN; k++)
        begin
            c[0].v[k] = s_tdata[k*Q_W +: Q_W];
        end
    end

    for (genvar i = 0; i < NOPS; i++) begin : g_op
        if (OPS[i].kind == OP_SQRT) begin : g_sqrt
            smi_sqrt_unit #(
                .FRAC_BITS (FRAC_BITS),
                .OP        (OPS[i])
            ) u_unit (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (en),
                .ci    (c[i]),
                .co    (c[i+1])
            );
        end
        else if (OPS[i].kind == OP_DIV) begin : g_div
            smi_div_unit #(
                .FRAC_BITS (FRAC_BITS),
                .OP        (OPS[i])
            ) u_unit (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (en),
                .ci    (c[i]),
                .co    (c[i+1])
            );
        end
        else begin : g_acc
            smi_acc_unit #(
                .FRAC_BITS (FRAC_BITS),
                .OP        (OPS[i])
            ) u_unit (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (en),
                .ci    (c[i]),
                .co    (c[i+1])
            );
        end
    end

    // The last unit ends in a register, which serves as the output slot.
    assign m_tvalid = c[NOPS].valid;

    always_comb
    begin
        for (int k = 0; k < NIN; k++)
        begin
            m_tdata[k*Q_W +: Q_W] = c[NOPS].bad ? '0 : c[NOPS].v[int'(S_R00) + k];
        end
        if (c[NOPS].bad)
        begin
            m_tuser = ST_PIVOT;
        end
        else if (c[NOPS].sat)
        begin
            m_tuser = ST_SAT;
        end
        else
        begin
            m_tuser = ST_OK;
        end
    end

endmodule

>>> hw/rtl/smi_acc_unit.sv
// ----------------------------------------------------------------------------
// smi_acc_unit: accumulator step
// Loads, clears or presets acc, or adds or subtracts a rounded product.
// ----------------------------------------------------------------------------
module smi_acc_unit #(
    parameter int              FRAC_BITS = smi_pkg::FRAC_BITS_DEF,
    parameter smi_pkg::smi_op_t OP       = '0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  smi_pkg::smi_ctx_t ci,
    output smi_pkg::smi_ctx_t co
);
    import smi_pkg::*;

    if (OP.kind == OP_MAC) begin : g_mac
        smi_ctx_t                  ctx_reg;
        smi_ctx_t                  out_reg;
        smi_ctx_t                  out_next;
        logic signed [2*Q_W-1:0]   prod_reg;
        logic [63:0]               mag;
        logic [63:0]               rnd;
        logic [63:0]               lim;
        logic [63:0]               mq;
        logic                      clip;
        logic [ACC_W-1:0]          term;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctx_reg <= '0;
                out_reg <= '0;
            end
            else if (en)
            begin
                ctx_reg <= ci;
                out_reg <= out_next;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_reg <= signed'(ci.v[OP.a]) * signed'(ci.v[OP.b]);
            end
        end

        // Round half away from zero on the magnitude, then clip to 32 bits.
        always_comb
        begin
            mag  = prod_reg[2*Q_W-1] ? (64'd0 - 64'(prod_reg)) : 64'(prod_reg);
            rnd  = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            lim  = prod_reg[2*Q_W-1] ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
            clip = rnd > lim;
            mq   = clip ? lim : rnd;
            term = {{(ACC_W-Q_W){1'b0}}, mq[Q_W-1:0]};
            out_next = ctx_reg;
            out_next.sat = ctx_reg.sat | clip;
            if (prod_reg[2*Q_W-1] ^ OP.neg)
            begin
                out_next.acc = ctx_reg.acc - signed'(term);
            end
            else
            begin
                out_next.acc = ctx_reg.acc + signed'(term);
            end
        end

        assign co = out_reg;
    end
    else begin : g_set
        smi_ctx_t ctx_reg;
        smi_ctx_t ctx_next;

        always_comb
        begin
            ctx_next = ci;
            case (OP.kind)
                OP_LOAD: ctx_next.acc = ACC_W'(signed'(ci.v[OP.a]));
                OP_CLR:  ctx_next.acc = '0;
                OP_ONE:  ctx_next.acc = ACC_W'(1) << FRAC_BITS;
                default: ctx_next.acc = ci.acc;
            endcase
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctx_reg <= '0;
            end
            else if (en)
            begin
                ctx_reg <= ctx_next;
            end
        end

        assign co = ctx_reg;
    end

endmodule

>>> hw/rtl/smi_div_cell.sv
// ----------------------------------------------------------------------------
// smi_div_cell: one quotient bit
// Restoring division step at a fixed bit position of the quotient.
// ----------------------------------------------------------------------------
module smi_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  smi_pkg::smi_ctx_t ci,
    input  smi_pkg::smi_div_t di,
    output smi_pkg::smi_ctx_t co,
    output smi_pkg::smi_div_t dout
);
    import smi_pkg::*;

    smi_ctx_t    ctx_reg;
    smi_div_t    div_reg;
    smi_div_t    div_next;
    logic [63:0] dsh;
    logic        ge;

    always_comb
    begin
        dsh      = {32'd0, di.dvs} << SHIFT;
        ge       = di.rem >= dsh;
        div_next = di;
        if (ge)
        begin
            div_next.rem        = di.rem - dsh;
            div_next.quo[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg <= '0;
        end
        else if (en)
        begin
            ctx_reg <= ci;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div_reg <= div_next;
        end
    end

    assign co   = ctx_reg;
    assign dout = div_reg;

endmodule

>>> hw/rtl/smi_div_unit.sv
// ----------------------------------------------------------------------------
// smi_div_unit: fixed-point divider
// Saturated accumulator over a slot, rounded, one quotient bit per cell.
// ----------------------------------------------------------------------------
module smi_div_unit #(
    parameter int              FRAC_BITS = smi_pkg::FRAC_BITS_DEF,
    parameter smi_pkg::smi_op_t OP       = '0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  smi_pkg::smi_ctx_t ci,
    output smi_pkg::smi_ctx_t co
);
    import smi_pkg::*;

    localparam int DIV_STEPS = Q_W;

    smi_ctx_t       cx [DIV_STEPS+1];
    smi_div_t       dx [DIV_STEPS+1];
    smi_ctx_t       pre_ctx;
    smi_div_t       pre_div;
    smi_ctx_t       ctx0_reg;
    smi_div_t       div0_reg;
    smi_ctx_t       out_reg;
    smi_ctx_t       out_next;
    logic [Q_W-1:0] num;
    logic           num_clip;
    logic [Q_W-1:0] mag;
    logic           big;
    logic           wrap;
    logic [Q_W-1:0] val;
    logic [Q_W-1:0] res;

    // Numerator is the accumulator clipped to 32 bits; the half divisor
    // added up front gives rounding to nearest.
    always_comb
    begin
        num_clip = 1'b0;
        if (ci.acc > ACC_QMAX)
        begin
            num      = 32'h7FFF_FFFF;
            num_clip = 1'b1;
        end
        else if (ci.acc < ACC_QMIN)
        begin
            num      = 32'h8000_0000;
            num_clip = 1'b1;
        end
        else
        begin
            num = ci.acc[Q_W-1:0];
        end
        mag         = num[Q_W-1] ? (32'd0 - num) : num;
        pre_div.dvs = ci.v[OP.b];
        pre_div.neg = num[Q_W-1];
        pre_div.quo = '0;
        pre_div.rem = ({32'd0, mag} << FRAC_BITS) + {33'd0, pre_div.dvs[Q_W-1:1]};
        pre_div.ovf = pre_div.rem >= {pre_div.dvs, 32'd0};
        pre_ctx     = ci;
        pre_ctx.sat = ci.sat | num_clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx0_reg <= '0;
            out_reg  <= '0;
        end
        else if (en)
        begin
            ctx0_reg <= pre_ctx;
            out_reg  <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            div0_reg <= pre_div;
        end
    end

    assign cx[0] = ctx0_reg;
    assign dx[0] = div0_reg;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
        smi_div_cell #(
            .SHIFT (DIV_STEPS - 1 - k)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .ci    (cx[k]),
            .di    (dx[k]),
            .co    (cx[k+1]),
            .dout  (dx[k+1])
        );
    end

    // Apply the sign and clip; a negated quotient may clip once more.
    always_comb
    begin
        big = dx[DIV_STEPS].ovf ||
              ({1'b0, dx[DIV_STEPS].quo} >
               (dx[DIV_STEPS].neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF));
        if (big)
        begin
            val = dx[DIV_STEPS].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            val = dx[DIV_STEPS].neg ? (32'd0 - dx[DIV_STEPS].quo) : dx[DIV_STEPS].quo;
        end
        wrap = 1'b0;
        res  = val;
        if (OP.neg)
        begin
            wrap = val == 32'h8000_0000;
            res  = wrap ? 32'h7FFF_FFFF : (32'd0 - val);
        end
        out_next         = cx[DIV_STEPS];
        out_next.v[OP.a] = res;
        out_next.sat     = cx[DIV_STEPS].sat | big | wrap;
    end

    assign co = out_reg;

endmodule

>>> hw/rtl/smi_sqrt_unit.sv
// ----------------------------------------------------------------------------
// smi_sqrt_unit: fixed-point square root
// Pivot check and bit-by-bit integer root, one result bit per cell.
// ----------------------------------------------------------------------------
module smi_sqrt_unit #(
    parameter int              FRAC_BITS = smi_pkg::FRAC_BITS_DEF,
    parameter smi_pkg::smi_op_t OP       = '0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  smi_pkg::smi_ctx_t ci,
    output smi_pkg::smi_ctx_t co
);
    import smi_pkg::*;

    localparam int SQ_STEPS = 32;

    smi_ctx_t         ctx_in  [SQ_STEPS];
    smi_sqrt_t        sq_in   [SQ_STEPS];
    smi_ctx_t         ctx_reg [SQ_STEPS];
    smi_sqrt_t        sq_reg  [SQ_STEPS];
    logic             pos;
    logic [ACC_W-1:0] x;

    // A pivot that is zero or negative marks the item and roots zero.
    always_comb
    begin
        pos            = ci.acc > 0;
        x              = pos ? ci.acc : '0;
        ctx_in[0]      = ci;
        ctx_in[0].bad  = ci.bad | !pos;
        sq_in[0].rad   = {{(64-ACC_W){1'b0}}, x} << FRAC_BITS;
        sq_in[0].root  = '0;
    end

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_cell
        localparam logic [63:0] BITV = 64'd1 << (62 - 2 * j);
        smi_sqrt_t   sq_next;
        logic [63:0] trial;

        if (j > 0) begin : g_link
            assign ctx_in[j] = ctx_reg[j-1];
            assign sq_in[j]  = sq_reg[j-1];
        end

        always_comb
        begin
            trial   = sq_in[j].root + BITV;
            sq_next = sq_in[j];
            if (sq_in[j].rad >= trial)
            begin
                sq_next.rad  = sq_in[j].rad - trial;
                sq_next.root = (sq_in[j].root >> 1) + BITV;
            end
            else
            begin
                sq_next.root = sq_in[j].root >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctx_reg[j] <= '0;
            end
            else if (en)
            begin
                ctx_reg[j] <= ctx_in[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[j] <= sq_next;
            end
        end
    end

    always_comb
    begin
        co         = ctx_reg[SQ_STEPS-1];
        co.v[OP.a] = sq_reg[SQ_STEPS-1].root[Q_W-1:0];
    end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for spd_matrix_inverse_4x4_core
// Streams symmetric matrices into the core and checks each returned inverse
// and its status against a bit-exact fixed-point predictor in this file.
// Both stream sides idle at random, and the output is held off for a long
// stretch so that the chain stalls and refuses its input.
// ----------------------------------------------------------------------------
module testbench;

    import smi_pkg::*;

    localparam int  FRAC      = FRAC_BITS_DEF;
    localparam longint QMAX   = 64'sd2147483647;
    localparam longint QMIN   = -64'sd2147483648;
    localparam longint UNITY  = 64'sd1 << FRAC;
    localparam int  LATENCY   = 1102;

    typedef struct {
        logic [319:0] data;
        logic [1:0]   status;
    } inverse_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [319:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [319:0] m_tdata;
    logic [1:0]   m_tuser;

    inverse_t pending_inverses[$];
    int       fail_count = 0;
    bit       quiet = 1'b0;         // no idling on either side
    int       sink_hold = 0;        // cycles of a long output hold-off
    bit       sat_hit;

    spd_matrix_inverse_4x4_core uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Fixed-point helpers; every one of them raises sat_hit when it clips.
    function automatic longint clip(input longint v);
        if (v > QMAX)
        begin
            sat_hit = 1'b1;
            return QMAX;
        end
        if (v < QMIN)
        begin
            sat_hit = 1'b1;
            return QMIN;
        end
        return v;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        longint p;
        longint m;
        p = a * b;
        m = (p < 0) ? -p : p;
        m = (m + (64'sd1 << (FRAC - 1))) >>> FRAC;
        return clip((p < 0) ? -m : m);
    endfunction

    function automatic longint fx_div(input longint a, input longint b);
        longint m;
        longint q;
        if (b <= 0)
            return 0;
        m = (a < 0) ? -a : a;
        q = ((m << FRAC) + b / 2) / b;
        return clip((a < 0) ? -q : q);
    endfunction

    function automatic longint fx_sqrt(input longint x);
        longint unsigned v;
        longint unsigned res;
        longint unsigned bitv;
        v = longint'(x) << FRAC;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    // Cholesky factor, forward substitution for the inverse factor, then back
    // substitution with the transposed factor.
    function automatic inverse_t predict_inverse(input logic [319:0] packed_m);
        longint a[4][4];
        longint l[4][4];
        longint u00, u10, u11, u20, u21, u22, u30, u31, u32, u33;
        longint r[10];
        longint sum;
        longint d;
        bit bad;
        int idx;
        inverse_t res;
        sat_hit = 1'b0;
        bad = 1'b0;
        idx = 0;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                l[i][j] = 0;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j <= i; j++)
            begin
                a[i][j] = longint'($signed(packed_m[idx*32 +: 32]));
                idx++;
            end
        for (int i = 0; i < 4; i++)
            for (int j = 0; j <= i; j++)
                if (!bad)
                begin
                    sum = 0;
                    for (int k = 0; k < j; k++)
                        sum += fx_mul(l[i][k], l[j][k]);
                    if (i == j)
                    begin
                        d = a[i][i] - sum;
                        if (d <= 0)
                            bad = 1'b1;
                        else
                            l[i][i] = fx_sqrt(d);
                    end
                    else
                        l[i][j] = fx_div(clip(a[i][j] - sum), l[j][j]);
                end
        if (bad)
        begin
            res.data = '0;
            res.status = ST_PIVOT;
            return res;
        end
        u00 = fx_div(UNITY, l[0][0]);
        u11 = fx_div(UNITY, l[1][1]);
        u22 = fx_div(UNITY, l[2][2]);
        u33 = fx_div(UNITY, l[3][3]);
        u10 = clip(-fx_div(fx_mul(u00, l[1][0]), l[1][1]));
        u21 = clip(-fx_div(fx_mul(u11, l[2][1]), l[2][2]));
        u32 = clip(-fx_div(fx_mul(u22, l[3][2]), l[3][3]));
        u20 = clip(-fx_div(clip(fx_mul(u00, l[2][0]) + fx_mul(u10, l[2][1])), l[2][2]));
        u31 = clip(-fx_div(clip(fx_mul(u11, l[3][1]) + fx_mul(u21, l[3][2])), l[3][3]));
        u30 = clip(-fx_div(clip(fx_mul(u00, l[3][0]) + fx_mul(u10, l[3][1])
                                + fx_mul(u20, l[3][2])), l[3][3]));
        r[6] = fx_div(u30, l[3][3]);
        r[7] = fx_div(u31, l[3][3]);
        r[8] = fx_div(u32, l[3][3]);
        r[9] = fx_div(u33, l[3][3]);
        r[3] = fx_div(clip(u20 - fx_mul(l[3][2], r[6])), l[2][2]);
        r[4] = fx_div(clip(u21 - fx_mul(l[3][2], r[7])), l[2][2]);
        r[5] = fx_div(clip(u22 - fx_mul(l[3][2], r[8])), l[2][2]);
        r[1] = fx_div(clip(u10 - fx_mul(l[2][1], r[3]) - fx_mul(l[3][1], r[6])), l[1][1]);
        r[2] = fx_div(clip(u11 - fx_mul(l[2][1], r[4]) - fx_mul(l[3][1], r[7])), l[1][1]);
        r[0] = fx_div(clip(u00 - fx_mul(l[1][0], r[1]) - fx_mul(l[2][0], r[3])
                           - fx_mul(l[3][0], r[6])), l[0][0]);
        for (int i = 0; i < 10; i++)
            res.data[i*32 +: 32] = r[i][31:0];
        res.status = sat_hit ? ST_SAT : ST_OK;
        return res;
    endfunction

    // Offer one matrix, with an occasional gap before it, and record the
    // predicted inverse once the transaction completes.
    task automatic send_matrix(input logic [319:0] mat);
        inverse_t want;
        want = predict_inverse(mat);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= mat;
        do
            @(posedge clk);
        while (!s_tready);
        pending_inverses.push_back(want);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_inverses.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [319:0] pack10(input longint v[10]);
        logic [319:0] p;
        for (int i = 0; i < 10; i++)
            p[i*32 +: 32] = v[i][31:0];
        return p;
    endfunction

    function automatic logic [319:0] diag_matrix(input longint dv);
        longint v[10];
        for (int i = 0; i < 10; i++)
            v[i] = 0;
        v[0] = dv;
        v[2] = dv;
        v[5] = dv;
        v[9] = dv;
        return pack10(v);
    endfunction

    // Diagonally dominant matrix at a random scale; small scales drive the
    // inverse into saturation.
    function automatic logic [319:0] random_spd();
        longint v[10];
        longint span;
        longint rowsum[4];
        int idx;
        int scale;
        scale = $urandom_range(0, 12);
        span = 64'sd1 << (scale + 14);
        idx = 0;
        for (int i = 0; i < 4; i++)
            rowsum[i] = 0;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j <= i; j++)
            begin
                if (i != j)
                begin
                    v[idx] = longint'($urandom_range(0, 2 * span)) - span;
                    rowsum[i] += (v[idx] < 0) ? -v[idx] : v[idx];
                    rowsum[j] += (v[idx] < 0) ? -v[idx] : v[idx];
                end
                idx++;
            end
        v[0] = rowsum[0] + $urandom_range(1, 4 * span);
        v[2] = rowsum[1] + $urandom_range(1, 4 * span);
        v[5] = rowsum[2] + $urandom_range(1, 4 * span);
        v[9] = rowsum[3] + $urandom_range(1, 4 * span);
        return pack10(v);
    endfunction

    function automatic logic [319:0] random_bits();
        logic [319:0] p;
        for (int i = 0; i < 10; i++)
            p[i*32 +: 32] = $urandom();
        return p;
    endfunction

    // Output side: random stalls, and a long hold-off when one is requested.
    initial
    begin
        forever
        begin
            if (sink_hold > 0)
            begin
                m_tready <= 1'b0;
                repeat (sink_hold) @(posedge clk);
                sink_hold = 0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Compare every returned transaction with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_inverses.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h status %0d",
                         $time, m_tdata, m_tuser);
                fail_count++;
            end
            else
            begin
                inverse_t want;
                want = pending_inverses.pop_front();
                for (int i = 0; i < 10; i++)
                    if (m_tdata[i*32 +: 32] !== want.data[i*32 +: 32])
                    begin
                        $display("%0t: field %0d mismatch, expected %h, actual %h",
                                 $time, i, want.data[i*32 +: 32], m_tdata[i*32 +: 32]);
                        fail_count++;
                    end
                if (m_tuser !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_directed();
        longint v[10];
        send_matrix(diag_matrix(UNITY));                 // identity
        send_matrix(diag_matrix(4 * UNITY));
        send_matrix(diag_matrix(QMAX));                  // largest diagonal
        send_matrix(diag_matrix(1));                     // tiny pivot, saturates
        send_matrix(diag_matrix(0));                     // zero pivot
        send_matrix(diag_matrix(QMIN));                  // most negative pivot
        send_matrix({32{10'h3ff}});                      // all ones
        send_matrix('0);
        for (int i = 0; i < 10; i++)
            v[i] = (i == 0 || i == 2 || i == 5 || i == 9) ? QMAX : QMIN;
        send_matrix(pack10(v));                          // extreme off-diagonals
        for (int i = 0; i < 10; i++)
            v[i] = (i == 0 || i == 2 || i == 5 || i == 9) ? 4 * UNITY : UNITY;
        send_matrix(pack10(v));                          // dense well-formed
        v[9] = UNITY;
        send_matrix(pack10(v));                          // smaller last pivot, still positive definite
        v[9] = 4 * UNITY;
        v[2] = -UNITY;
        send_matrix(pack10(v));                          // second pivot negative
        for (int i = 0; i < 10; i++)
            v[i] = (i == 0 || i == 2 || i == 5 || i == 9) ? 2 * UNITY : -UNITY + 1;
        send_matrix(pack10(v));
        for (int i = 0; i < 10; i++)
            v[i] = (i == 0 || i == 2 || i == 5 || i == 9) ? 300 : 299;
        send_matrix(pack10(v));                          // near singular
        send_matrix(diag_matrix(UNITY / 2 + 1));
        wait_drained();
    endtask

    // Hold the output off long enough for the chain to stall and refuse input.
    // The sender keeps offering well past the point where the first result
    // reaches the output, so the input is refused for a long stretch.
    task automatic test_backpressure();
        sink_hold = 3 * LATENCY;
        repeat (700)
            send_matrix(random_spd());
        wait_drained();
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++)
            if ($urandom_range(0, 3) == 0)
                send_matrix(random_bits());
            else
                send_matrix(random_spd());
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(160);
        quiet = 1'b1;
        test_random(180);
        wait_drained();
        repeat (LATENCY + 50) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> spd_matrix_inverse_4x4_core.f
hw/rtl/smi_pkg.sv
hw/rtl/smi_acc_unit.sv
hw/rtl/smi_div_cell.sv
hw/rtl/smi_div_unit.sv
hw/rtl/smi_sqrt_unit.sv
hw/rtl/spd_matrix_inverse_4x4_core.sv
verif/testbench.sv
